FILE: rtl/sorted_timer_queue_macros.svh
// Assertion macros of the sorted timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define STQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define STQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stq_pkg.sv
// Shared constants, types and helpers of the sorted timer queue.
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  localparam int ACT_W  = 2;
  localparam int ID_W   = 4;
  localparam int AMT_W  = 32;
  localparam int PRIO_W = 3;
  localparam int DL_W   = 32;

  localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EXPIRE  = 2'd3;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Read address source of the slot memory.
  typedef enum logic [1:0] {
    RD_ID,
    RD_HEAD,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_start;
    logic    wr_restart;
    logic    rm_id;
    logic    rm_head;
    logic    pos_clr;
    logic    pos_inc;
    logic    ins;
    logic    emit_fire_id;
    logic    emit_fire_head;
    logic    emit_status;
  } stq_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             in_range;
    logic             amt_zero;
    logic             list_empty;
    logic             walk_end;
    logic             walk_le;
    logic             head_due;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } stq_stat_t;

  // Wrap-around compare: a is at or before b.
  function automatic logic at_or_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage

FILE: rtl/sorted_timer_queue.sv
// Sorted timer queue: 16 slots, one list sorted by wrap-around expiry, status after each action.
// A zero-delay start emits a fired item ahead of its status item, and an expire check emits
// one fired item per due timer before it; start and restart walk the list to the insert point.
// Throughput: one transaction at a time, the next accepted once the status item is loaded.
// Reset empties the queue and the output register; slot times and priorities stay unknown.
`include "sorted_timer_queue_macros.svh"

module sorted_timer_queue (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [stq_pkg::ACT_W-1:0]   action,
  input  logic [stq_pkg::ID_W-1:0]    timer_id,
  input  logic [stq_pkg::AMT_W-1:0]   amount,
  input  logic [stq_pkg::PRIO_W-1:0]  prio,
  input  logic [stq_pkg::AMT_W-1:0]   now,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kind,
  output logic [stq_pkg::ID_W-1:0]    fired_id,
  output logic [stq_pkg::PRIO_W-1:0]  fired_prio,
  output logic [stq_pkg::DL_W-1:0]    deadline,
  output logic                        deadline_valid,
  output logic                        last
);
  import stq_pkg::*;

  // The controller sequences each transaction: decode, unlink the slot, write its
  // new expiry, walk the list to the insertion point, then emit fired items and
  // finally the status item. The datapath owns the slot memory, the order list,
  // the queued flags and count, and the output register.
  stq_cmd_t  cmd;
  stq_stat_t stat;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .timer_id       (timer_id),
    .amount         (amount),
    .prio           (prio),
    .now            (now),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .kind           (kind),
    .fired_id       (fired_id),
    .fired_prio     (fired_prio),
    .deadline       (deadline),
    .deadline_valid (deadline_valid),
    .last           (last)
  );

  // A transaction just taken keeps the input side closed for its whole run.
  `STQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
  // The status item, and only it, closes a transaction.
  `STQ_ASSERT_IMP(a_last_is_status, out_valid, kind == last, "last flag and kind disagree")
  // Each slot is queued at most once, so the count never passes the slot total.
  `STQ_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= CNT_W'(NUM_TIMERS), "queue count overflow")
  // A result is loaded only when the output register is free or being drained.
  `STQ_ASSERT_IMP(a_emit_free, cmd.emit_fire_id || cmd.emit_fire_head || cmd.emit_status,
    stat.out_free, "result overwrote a pending transaction")

endmodule

FILE: rtl/stq_ctrl.sv
// Sequencing state machine of the sorted timer queue.
module stq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stq_pkg::stq_stat_t stat,
  output stq_pkg::stq_cmd_t  cmd
);
  import stq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESTART,
    S_INS_START,
    S_INS_WALK,
    S_INS_DO,
    S_FIRE,
    S_EXP_START,
    S_EXP_CHK,
    S_STAT_START,
    S_STAT_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.act == ACT_EXPIRE) begin
          state_next = S_EXP_START;
        end else if (!stat.in_range) begin
          state_next = S_STAT_START;
        end else begin
          // drop the slot from the list if it is queued
          cmd.rm_id = 1'b1;
          priority if (stat.act == ACT_START) begin
            cmd.wr_start = 1'b1;
            state_next   = stat.amt_zero ? S_FIRE : S_INS_START;
          end else if (stat.act == ACT_RESTART) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ID;
            state_next = S_RESTART;
          end else begin
            state_next = S_STAT_START;
          end
        end
      end
      S_RESTART: begin
        cmd.wr_restart = 1'b1;
        state_next     = S_INS_START;
      end
      S_INS_START: begin
        cmd.pos_clr = 1'b1;
        if (stat.list_empty) begin
          state_next = S_INS_DO;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (stat.walk_le) begin
          cmd.pos_inc = 1'b1;
          if (stat.walk_end) begin
            state_next = S_INS_DO;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
          end
        end else begin
          state_next = S_INS_DO;
        end
      end
      S_INS_DO: begin
        cmd.ins    = 1'b1;
        state_next = S_STAT_START;
      end
      S_FIRE: begin
        if (stat.out_free) begin
          cmd.emit_fire_id = 1'b1;
          state_next       = S_STAT_START;
        end
      end
      S_EXP_START: begin
        if (stat.list_empty) begin
          state_next = S_STAT_START;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (!stat.head_due) begin
          state_next = S_STAT_START;
        end else if (stat.out_free) begin
          cmd.emit_fire_head = 1'b1;
          cmd.rm_head        = 1'b1;
          state_next         = S_EXP_START;
        end
      end
      S_STAT_START: begin
        if (stat.list_empty) begin
          if (stat.out_free) begin
            cmd.emit_status = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_STAT_EMIT;
        end
      end
      S_STAT_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/stq_datapath.sv
// Slot memory, sorted order list and output register of the sorted timer queue.
module stq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  stq_pkg::stq_cmd_t           cmd,
  output stq_pkg::stq_stat_t          stat,
  input  logic [stq_pkg::ACT_W-1:0]   action,
  input  logic [stq_pkg::ID_W-1:0]    timer_id,
  input  logic [stq_pkg::AMT_W-1:0]   amount,
  input  logic [stq_pkg::PRIO_W-1:0]  prio,
  input  logic [stq_pkg::AMT_W-1:0]   now,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        kind,
  output logic [stq_pkg::ID_W-1:0]    fired_id,
  output logic [stq_pkg::PRIO_W-1:0]  fired_prio,
  output logic [stq_pkg::DL_W-1:0]    deadline,
  output logic                        deadline_valid,
  output logic                        last
);
  import stq_pkg::*;

  // latched transaction
  logic [ACT_W-1:0]  act_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] amt_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] new_exp;

  logic [SLOT_W-1:0] order_list [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] queued;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;

  entry_t            mem [NUM_TIMERS];
  entry_t            rd_data;
  entry_t            wr_data;
  logic              wr_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] next_idx;

  logic [SLOT_W-1:0]     rm_slot;
  logic                  rm_go;
  logic [NUM_TIMERS-1:0] match;
  logic [NUM_TIMERS-1:0] shift_ge;
  logic                  out_free;
  logic                  emit_any;

  assign slot_q   = SLOT_W'(id_q);
  assign next_idx = SLOT_W'(pos + CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      id_q   <= timer_id;
      amt_q  <= TIME_W'(amount);
      prio_q <= prio;
      now_q  <= TIME_W'(now);
    end
  end

  // slot memory: one write and one registered read port
  always_comb begin
    unique case (cmd.rd_sel)
      RD_ID:   rd_addr = slot_q;
      RD_HEAD: rd_addr = order_list[0];
      RD_NEXT: rd_addr = order_list[next_idx];
      default: rd_addr = slot_q;
    endcase
  end

  always_comb begin
    wr_en = cmd.wr_start || cmd.wr_restart;
    if (cmd.wr_restart) begin
      wr_data.prio   = rd_data.prio;
      wr_data.expiry = rd_data.expiry + amt_q;
    end else begin
      wr_data.prio   = prio_q;
      wr_data.expiry = now_q + amt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_q] <= wr_data;
      new_exp     <= wr_data.expiry;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // removal: find the slot in the live part of the list, close the gap
  assign rm_slot = cmd.rm_head ? order_list[0] : slot_q;
  assign rm_go   = (cmd.rm_head || cmd.rm_id) && queued[rm_slot];

  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      match[j] = (order_list[j] == rm_slot) && (CNT_W'(j) < count);
    end
    for (int j = 0; j < NUM_TIMERS; j++) begin
      shift_ge[j] = |(match & ({NUM_TIMERS{1'b1}} >> (NUM_TIMERS - 1 - j)));
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_list
    localparam int UP = (g > 0) ? g - 1 : 0;
    localparam int DN = (g < NUM_TIMERS - 1) ? g + 1 : g;
    localparam logic [CNT_W-1:0] GIDX = CNT_W'(g);
    always_ff @(posedge clk) begin
      if (rm_go && shift_ge[g]) begin
        order_list[g] <= order_list[DN];
      end else if (cmd.ins && (GIDX > pos)) begin
        order_list[g] <= order_list[UP];
      end else if (cmd.ins && (GIDX == pos)) begin
        order_list[g] <= slot_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queued <= '0;
      count  <= '0;
    end else begin
      if (rm_go) begin
        queued[rm_slot] <= 1'b0;
        count           <= count - CNT_W'(1);
      end
      if (cmd.ins) begin
        queued[slot_q] <= 1'b1;
        count          <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + CNT_W'(1);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;
  assign emit_any = cmd.emit_fire_id || cmd.emit_fire_head || cmd.emit_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fire_id) begin
      kind           <= KIND_FIRED;
      fired_id       <= id_q;
      fired_prio     <= prio_q;
      deadline       <= '0;
      deadline_valid <= 1'b0;
      last           <= 1'b0;
    end else if (cmd.emit_fire_head) begin
      kind           <= KIND_FIRED;
      fired_id       <= ID_W'(order_list[0]);
      fired_prio     <= rd_data.prio;
      deadline       <= '0;
      deadline_valid <= 1'b0;
      last           <= 1'b0;
    end else if (cmd.emit_status) begin
      kind           <= KIND_STATUS;
      fired_id       <= '0;
      fired_prio     <= '0;
      deadline       <= (count != '0) ? DL_W'(rd_data.expiry) : '0;
      deadline_valid <= (count != '0);
      last           <= 1'b1;
    end
  end

  always_comb begin
    stat.act        = act_q;
    stat.in_range   = (int'(id_q) < NUM_TIMERS);
    stat.amt_zero   = (amt_q == '0);
    stat.list_empty = (count == '0);
    stat.walk_end   = ((pos + CNT_W'(1)) == count);
    stat.walk_le    = at_or_before(rd_data.expiry, new_exp);
    stat.head_due   = at_or_before(rd_data.expiry, now_q);
    stat.out_free   = out_free;
    stat.count      = count;
  end

endmodule

FILE: sim/sorted_timer_queue_test.sv
// Self-checking testbench for the sorted timer queue: directed, full-queue, stall and random tests.
`timescale 1ns / 1ps

module sorted_timer_queue_test;
  import stq_pkg::*;

  // Longest stretch with no transaction on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES    = 400;
  // Quiet time after the last expected result; longer than a 16-timer expire check.
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   fired_id;
    logic [PRIO_W-1:0] fired_prio;
    logic [DL_W-1:0]   deadline;
    logic              deadline_valid;
    logic              last;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ACT_W-1:0]  action = ACT_EXPIRE;
  logic [ID_W-1:0]   timer_id = '0;
  logic [AMT_W-1:0]  amount = '0;
  logic [PRIO_W-1:0] prio = '0;
  logic [AMT_W-1:0]  now = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [ID_W-1:0]   fired_id;
  logic [PRIO_W-1:0] fired_prio;
  logic [DL_W-1:0]   deadline;
  logic              deadline_valid;
  logic              last;

  sorted_timer_queue uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .timer_id       (timer_id),
    .amount         (amount),
    .prio           (prio),
    .now            (now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .fired_id       (fired_id),
    .fired_prio     (fired_prio),
    .deadline       (deadline),
    .deadline_valid (deadline_valid),
    .last           (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Timer list predictor. Membership in timer_order is the queued flag; the
  // list holds slot numbers sorted by wrap-around expiry, ties in arrival order.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] armed_expiry [NUM_TIMERS];
  logic [PRIO_W-1:0] armed_prio   [NUM_TIMERS];
  logic [ID_W-1:0]   timer_order[$];
  logic [NUM_TIMERS-1:0] slot_started = '0;

  timer_event_t expected_events[$];
  int error_count = 0;

  // Stimulus-side free-running time and idling controls.
  logic [AMT_W-1:0] wall_time = '0;
  logic calm = 1'b0;
  logic hold_off_req = 1'b0;

  // t counts as due by ref_t when t - ref_t wraps to zero or to a negative value.
  function automatic logic expires_by(logic [TIME_W-1:0] t, logic [TIME_W-1:0] ref_t);
    logic [TIME_W-1:0] diff;
    diff = t - ref_t;
    return (diff == '0) || diff[TIME_W-1];
  endfunction

  function automatic void unqueue_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < timer_order.size(); i++)
      if (timer_order[i] == id) begin
        timer_order.delete(i);
        return;
      end
  endfunction

  // Insert behind every queued timer due at or before this one.
  function automatic void enqueue_slot(logic [ID_W-1:0] id);
    int pos;
    pos = 0;
    while (pos < timer_order.size() &&
           expires_by(armed_expiry[timer_order[pos]], armed_expiry[id]))
      pos++;
    timer_order.insert(pos, id);
  endfunction

  function automatic void expect_event(logic k, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr,
                                       logic [DL_W-1:0] dl, logic dv, logic lst);
    timer_event_t ev;
    ev.kind           = k;
    ev.fired_id       = id;
    ev.fired_prio     = pr;
    ev.deadline       = dl;
    ev.deadline_valid = dv;
    ev.last           = lst;
    expected_events.push_back(ev);
  endfunction

  // Apply one accepted command to the timer list and queue the results it causes.
  function automatic void predict_timer_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                                logic [AMT_W-1:0] amt, logic [PRIO_W-1:0] pr,
                                                logic [AMT_W-1:0] tnow);
    logic [ID_W-1:0] head;
    case (act)
      ACT_START: begin
        unqueue_slot(id);
        armed_prio[id]   = pr;
        armed_expiry[id] = tnow + amt;
        slot_started[id] = 1'b1;
        // A zero delay fires at once and never enters the list.
        if (amt == '0)
          expect_event(KIND_FIRED, id, pr, '0, 1'b0, 1'b0);
        else
          enqueue_slot(id);
      end
      ACT_RESTART: begin
        unqueue_slot(id);
        armed_expiry[id] = armed_expiry[id] + amt;
        enqueue_slot(id);
      end
      ACT_STOP: unqueue_slot(id);
      default: begin
        while (timer_order.size() > 0 && expires_by(armed_expiry[timer_order[0]], tnow)) begin
          head = timer_order.pop_front();
          expect_event(KIND_FIRED, head, armed_prio[head], '0, 1'b0, 1'b0);
        end
      end
    endcase
    // Every command ends with the head deadline.
    if (timer_order.size() > 0)
      expect_event(KIND_STATUS, '0, '0, armed_expiry[timer_order[0]], 1'b1, 1'b1);
    else
      expect_event(KIND_STATUS, '0, '0, '0, 1'b0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: drive at the falling edge, hold until the transaction is
  // taken, then predict. Valid is only lowered for an idle burst or at the end.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                          input logic [AMT_W-1:0] amt, input logic [PRIO_W-1:0] pr,
                          input logic [AMT_W-1:0] tnow);
    @(negedge clk);
    // Now and then idle for a random burst before offering the command.
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    timer_id <= id;
    amount   <= amt;
    prio     <= pr;
    now      <= tnow;
    do @(posedge clk); while (!in_ready);
    predict_timer_command(act, id, amt, pr, tnow);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, one long hold-off on request, none
  // once the run turns calm.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [DL_W-1:0] want_v,
                                      logic [DL_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : event_check
    timer_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: kind %0d id %0d deadline 0x%0h", kind, fired_id, deadline);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("kind", DL_W'(want.kind), DL_W'(kind));
        check_field("fired_id", DL_W'(want.fired_id), DL_W'(fired_id));
        check_field("fired_prio", DL_W'(want.fired_prio), DL_W'(fired_prio));
        check_field("deadline", want.deadline, deadline);
        check_field("deadline_valid", DL_W'(want.deadline_valid), DL_W'(deadline_valid));
        check_field("last", DL_W'(want.last), DL_W'(last));
      end
    end
  end

  // Count cycles with no transaction on either side; a hang ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Expire and stop against an empty list.
  task automatic test_empty_queue();
    send_cmd(ACT_EXPIRE, '0, '0, '0, '0);
    send_cmd(ACT_STOP, 4'd9, '1, '1, '1);
  endtask

  // Zero delay fires at once, at both ends of the slot and priority range.
  task automatic test_immediate_fire();
    send_cmd(ACT_START, 4'd15, '0, 3'd7, 32'h1234_5678);
    send_cmd(ACT_START, 4'd0, '0, 3'd0, 32'hFFFF_FFFF);
  endtask

  // Sorting, ties in arrival order, requeue of a queued slot, restart, stop.
  task automatic test_ordering_and_ties();
    send_cmd(ACT_START, 4'd3, 32'd100, 3'd1, 32'd1000);
    send_cmd(ACT_START, 4'd5, 32'd50, 3'd2, 32'd1000);
    send_cmd(ACT_START, 4'd7, 32'd100, 3'd3, 32'd1000);   // ties with slot 3, goes behind
    send_cmd(ACT_START, 4'd3, 32'd100, 3'd4, 32'd1000);   // requeue: drop and reinsert
    send_cmd(ACT_RESTART, 4'd5, 32'd50, 3'd6, 32'd1010);
    send_cmd(ACT_STOP, 4'd7, 32'd5, 3'd5, 32'd1020);
    send_cmd(ACT_STOP, 4'd7, 32'd5, 3'd5, 32'd1020);      // no longer queued
    send_cmd(ACT_START, 4'd9, 32'hFFFF_FFFF, 3'd5, 32'd1000);  // expiry one tick behind now
    send_cmd(ACT_EXPIRE, 4'd1, '1, 3'd7, 32'd1099);
    send_cmd(ACT_EXPIRE, 4'd1, '0, 3'd0, 32'd1100);
  endtask

  // Expiry and now crossing the top of the time range.
  task automatic test_wraparound();
    send_cmd(ACT_START, 4'd2, 32'h30, 3'd2, 32'hFFFF_FFE0);
    send_cmd(ACT_START, 4'd4, 32'h10, 3'd4, 32'hFFFF_FFE0);
    send_cmd(ACT_EXPIRE, 4'd0, '0, '0, 32'hFFFF_FFF8);
    send_cmd(ACT_RESTART, 4'd4, 32'h7FFF_FFFF, 3'd0, 32'hFFFF_FFF8);
    send_cmd(ACT_EXPIRE, 4'd0, '0, '0, 32'h20);
    send_cmd(ACT_STOP, 4'd4, '0, '0, 32'h20);
  endtask

  // Fill every slot, with ties and at times a wrapped expiry, then fire all in one check.
  task automatic test_full_queue();
    wall_time = 32'hFFFF_FFC0;
    for (int s = 0; s < NUM_TIMERS; s++)
      send_cmd(ACT_START, ID_W'(s), $urandom_range(1, 8) * 8, PRIO_W'($urandom_range(0, 7)),
               wall_time);
    wall_time = wall_time + 32'd100;
    send_cmd(ACT_EXPIRE, ID_W'($urandom_range(0, 15)), $urandom,
             PRIO_W'($urandom_range(0, 7)), wall_time);
  endtask

  // Hold off the receiver while commands keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    for (int n = 0; n < 20; n++) begin
      wall_time = wall_time + $urandom_range(0, 20);
      if (n % 3 == 2)
        send_cmd(ACT_EXPIRE, ID_W'($urandom_range(0, 15)), $urandom,
                 PRIO_W'($urandom_range(0, 7)), wall_time);
      else
        send_cmd(ACT_START, ID_W'($urandom_range(0, 15)), $urandom_range(0, 30),
                 PRIO_W'($urandom_range(0, 7)), wall_time);
    end
  endtask

  // Mixed traffic with advancing time; the final stretch runs without idling.
  task automatic test_random_traffic(input int n_items, input int n_calm);
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amt;
    int pick;
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items - n_calm)
        calm = 1'b1;
      // Advance time mostly in small steps, now and then jump far.
      if ($urandom_range(0, 24) == 0)
        wall_time = wall_time + $urandom;
      else
        wall_time = wall_time + $urandom_range(0, 120);
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom_range(0, NUM_TIMERS - 1));
      amt  = $urandom;
      if (pick < 35) begin
        act = ACT_START;
        case ($urandom_range(0, 9))
          0: amt = '0;
          1: ;                                       // full-range delay
          2: if (timer_order.size() > 0)             // tie with a queued timer
               amt = armed_expiry[timer_order[$urandom_range(0, timer_order.size() - 1)]]
                     - wall_time;
          default: amt = $urandom_range(1, 600);
        endcase
      end else if (pick < 50) begin
        // Restart only slots that hold a written expiry.
        act = slot_started[id] ? ACT_RESTART : ACT_START;
        if ($urandom_range(0, 3) != 0)
          amt = $urandom_range(0, 400);
      end else if (pick < 65) begin
        act = ACT_STOP;
        if (timer_order.size() > 0 && $urandom_range(0, 2) != 0)
          id = timer_order[$urandom_range(0, timer_order.size() - 1)];
      end else begin
        act = ACT_EXPIRE;
      end
      send_cmd(act, id, amt, PRIO_W'($urandom_range(0, 7)), wall_time);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_immediate_fire();
    test_ordering_and_ties();
    test_wraparound();
    test_full_queue();
    test_output_backpressure();
    test_random_traffic(155, 40);

    @(negedge clk);
    in_valid <= 1'b0;
    // Drain the remaining results, then watch for strays.
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
